>>> rtl/assert_macros.svh
// Assertion macros for the merge RTL (used by kwm_datapath).
// Depends on nothing; each user supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define CHK_IMPLY(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> rtl/kwm_pkg.sv
// Shared types and constants for the k-way merge block.
// Depends on nothing.
package kwm_pkg;
   localparam int NUM_LISTS  = 8;
   localparam int LIST_DEPTH = 256;
   localparam int LIST_W     = $clog2(NUM_LISTS);
   localparam int CNT_W      = $clog2(NUM_LISTS + 1);
   localparam int DEPTH_W    = $clog2(LIST_DEPTH);
   localparam int POS_W      = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W     = LIST_W + DEPTH_W;
   localparam int VAL_W      = 32;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_PULL  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]              kind;
      logic [2:0]              list_id;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] merged_value;
      logic                    success;
      logic                    more;
      logic                    overflow;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic load;
      logic clear;
      logic build;
      logic build_next;
      logic sift;
      logic pop;
      logic refill;
      logic rsp_pull;
      logic rsp_empty;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic built;
      logic heap_empty;
      logic build_done;
      logic sift_done;
      logic exhausted;
   } stat_type;
endpackage

>>> rtl/kwm_datapath.sv
// Datapath of the merge: list store, list counters, head cache and heap.
// Depends on kwm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module kwm_datapath (
   input  logic             clock,
   input  logic             reset,
   input  kwm_pkg::req_type req_data,
   input  kwm_pkg::cmd_type cmd,
   output kwm_pkg::stat_type stat,
   output logic             rsp_valid,
   output kwm_pkg::rsp_type rsp_data
);
   import kwm_pkg::*;

   logic signed [VAL_W-1:0] store_mem [NUM_LISTS*LIST_DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]       rd_addr;

   req_type                 req_ff;
   logic [POS_W-1:0]        len_ff [NUM_LISTS];
   logic [POS_W-1:0]        pos_ff [NUM_LISTS];
   logic signed [VAL_W-1:0] head_ff [NUM_LISTS];
   logic [LIST_W-1:0]       heap_ff [NUM_LISTS];
   logic [CNT_W-1:0]        hcount_ff;
   logic [CNT_W-1:0]        k_ff;
   logic [LIST_W-1:0]       i_ff;
   logic [LIST_W-1:0]       root_ff;
   logic                    built_ff;
   logic signed [VAL_W-1:0] res_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   logic [LIST_W-1:0]       root;
   logic [POS_W-1:0]        pos_next;
   logic                    load_ok;
   logic [LIST_W-1:0]       bld_order [NUM_LISTS];
   logic [CNT_W-1:0]        bld_cnt;
   logic [CNT_W:0]          l_idx, r_idx, best, hc_ext;
   logic signed [VAL_W-1:0] best_key;

   assign root     = heap_ff[0];
   assign pos_next = pos_ff[root] + POS_W'(1);
   assign rd_addr  = {root, pos_next[DEPTH_W-1:0]};
   assign load_ok  = len_ff[req_ff.list_id] < POS_W'(LIST_DEPTH);

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         store_mem[{req_ff.list_id, len_ff[req_ff.list_id][DEPTH_W-1:0]}] <= req_ff.value;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // gather lists with values left, in list order
   always_comb begin
      bld_cnt = '0;
      for (int k = 0; k < NUM_LISTS; k++) begin
         bld_order[k] = '0;
      end
      for (int k = 0; k < NUM_LISTS; k++) begin
         if (pos_ff[k] < len_ff[k]) begin
            bld_order[bld_cnt[LIST_W-1:0]] = LIST_W'(k);
            bld_cnt = bld_cnt + CNT_W'(1);
         end
      end
   end

   // one sift-down level: pick smallest of node and children
   always_comb begin
      hc_ext   = {1'b0, hcount_ff};
      l_idx    = {1'b0, i_ff, 1'b1};
      r_idx    = l_idx + (CNT_W+1)'(1);
      best     = {2'b00, i_ff};
      best_key = head_ff[heap_ff[i_ff]];
      if (l_idx < hc_ext && head_ff[heap_ff[l_idx[LIST_W-1:0]]] < best_key) begin
         best     = l_idx;
         best_key = head_ff[heap_ff[l_idx[LIST_W-1:0]]];
      end
      if (r_idx < hc_ext && head_ff[heap_ff[r_idx[LIST_W-1:0]]] < best_key) begin
         best = r_idx;
      end
   end

   assign stat.built      = built_ff;
   assign stat.heap_empty = hcount_ff == '0;
   assign stat.build_done = k_ff == '0;
   assign stat.sift_done  = ({2'b00, i_ff} >= hc_ext) || (best == {2'b00, i_ff});
   assign stat.exhausted  = pos_next >= len_ff[root];

   // control state of the lists and heap
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LISTS; k++) begin
            len_ff[k] <= '0;
            pos_ff[k] <= '0;
         end
         hcount_ff    <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.load || cmd.rsp_pull || cmd.rsp_empty;
         if (cmd.clear) begin
            for (int k = 0; k < NUM_LISTS; k++) begin
               len_ff[k] <= '0;
               pos_ff[k] <= '0;
            end
            hcount_ff <= '0;
            built_ff  <= 1'b0;
         end
         if (cmd.load) begin
            if (load_ok) begin
               len_ff[req_ff.list_id] <= len_ff[req_ff.list_id] + POS_W'(1);
               built_ff <= 1'b0;
            end
         end
         if (cmd.build) begin
            hcount_ff <= bld_cnt;
            built_ff  <= 1'b1;
         end
         if (cmd.pop) begin
            pos_ff[root] <= pos_next;
            if (stat.exhausted) begin
               hcount_ff <= hcount_ff - CNT_W'(1);
            end
         end
      end
   end

   // payload registers: request, heads, heap order, sift index, result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.load) begin
         if (load_ok && pos_ff[req_ff.list_id] == len_ff[req_ff.list_id]) begin
            head_ff[req_ff.list_id] <= req_ff.value;
         end
         rsp_data_ff <= '{merged_value: '0, success: 1'b0, more: 1'b0,
                          overflow: !load_ok};
      end
      if (cmd.build) begin
         for (int k = 0; k < NUM_LISTS; k++) begin
            heap_ff[k] <= bld_order[k];
         end
         k_ff <= bld_cnt >> 1;
      end
      if (cmd.build_next) begin
         k_ff <= k_ff - CNT_W'(1);
         i_ff <= LIST_W'(k_ff - CNT_W'(1));
      end
      if (cmd.sift && !stat.sift_done) begin
         heap_ff[i_ff]               <= heap_ff[best[LIST_W-1:0]];
         heap_ff[best[LIST_W-1:0]]   <= heap_ff[i_ff];
         i_ff                        <= best[LIST_W-1:0];
      end
      if (cmd.pop) begin
         res_ff  <= head_ff[root];
         root_ff <= root;
         i_ff    <= '0;
         if (stat.exhausted) begin
            heap_ff[0] <= heap_ff[LIST_W'(hcount_ff - CNT_W'(1))];
         end
      end
      if (cmd.refill) begin
         head_ff[root_ff] <= rd_data_ff;
      end
      if (cmd.rsp_pull) begin
         rsp_data_ff <= '{merged_value: res_ff, success: 1'b1,
                          more: hcount_ff != '0, overflow: 1'b0};
      end
      if (cmd.rsp_empty) begin
         rsp_data_ff <= '{merged_value: '0, success: 1'b0, more: 1'b0, overflow: 1'b0};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CHK_IMPLY(a_hcount_range, clock, reset, 1'b1, hcount_ff <= CNT_W'(NUM_LISTS), "heap count over range")
   `CHK_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "back-to-back result strobes")
   `CHK_IMPLY(a_ovf_no_success, clock, reset, rsp_valid_ff && rsp_data_ff.overflow, !rsp_data_ff.success, "overflow with success")
   `CHK_NEXT(a_pop_nonempty, clock, reset, cmd.pop, !(cmd.rsp_empty), "pop followed by empty result")
endmodule

>>> rtl/kwm_ctrl.sv
// Controller of the merge: sequences load, clear, heap build, pop and sift.
// Depends on kwm_pkg.
module kwm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_kind,
   input  kwm_pkg::stat_type stat,
   output kwm_pkg::cmd_type  cmd,
   output logic              busy
);
   import kwm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_CLEAR, S_PULL, S_BUILD, S_BUILD_NEXT,
      S_SIFT_BUILD, S_POP, S_REFILL, S_SIFT_POP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  KIND_LOAD:  state_in = S_LOAD;
                  KIND_PULL:  state_in = S_PULL;
                  KIND_CLEAR: state_in = S_CLEAR;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_IDLE;
         end
         S_PULL: begin
            state_in = stat.built ? S_POP : S_BUILD;
         end
         S_BUILD: begin
            cmd.build = 1'b1;
            state_in  = S_BUILD_NEXT;
         end
         S_BUILD_NEXT: begin
            if (stat.build_done) begin
               state_in = S_POP;
            end else begin
               cmd.build_next = 1'b1;
               state_in       = S_SIFT_BUILD;
            end
         end
         S_SIFT_BUILD: begin
            cmd.sift = 1'b1;
            if (stat.sift_done) begin
               state_in = S_BUILD_NEXT;
            end
         end
         S_POP: begin
            if (stat.heap_empty) begin
               cmd.rsp_empty = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = stat.exhausted ? S_SIFT_POP : S_REFILL;
            end
         end
         S_REFILL: begin
            cmd.refill = 1'b1;
            state_in   = S_SIFT_POP;
         end
         S_SIFT_POP: begin
            cmd.sift = 1'b1;
            if (stat.sift_done) begin
               cmd.rsp_pull = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and the busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= state_in != S_IDLE;
      end
   end

   assign busy = busy_ff;
endmodule

>>> rtl/kway_merge_min_heap.sv
// K-way merge of sorted lists through a min-heap of list heads.
// Load: capture, write, then a registered result strobe. Clear: capture, then
// empty all lists and the heap; no result. Pull on a built heap: decode, pop,
// store read, a sift step per level plus a final compare; the first pull
// after a load adds a build. One word at a time; results cannot be stalled.
// Synchronous active-high reset empties all lists and the heap.
module kway_merge_min_heap (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kwm_pkg::req_type req_data,
   output logic             rsp_valid,
   output kwm_pkg::rsp_type rsp_data
);
   import kwm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   kwm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   kwm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule
